### sv/keyframe_curve_evaluator_core_assert.svh
// Assertion macros for the keyframe curve evaluator.
`ifndef KEYFRAME_CURVE_EVALUATOR_CORE_ASSERT_SVH
`define KEYFRAME_CURVE_EVALUATOR_CORE_ASSERT_SVH
// Implication checked every clock edge outside reset.
`define KCE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define KCE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

### sv/kce_pkg.sv
// Package: constants, types and command/status structs of the curve evaluator.
`default_nettype none
package kce_pkg;
   localparam int MaxPoints = 16;
   localparam int FracBits  = 15;
   localparam int MinSegLen = 4;

   localparam logic [2:0] ModeLinear  = 3'd0;
   localparam logic [2:0] ModeIn      = 3'd1;
   localparam logic [2:0] ModeOut     = 3'd2;
   localparam logic [2:0] ModeInOut   = 3'd3;
   localparam logic [2:0] ModeCubic   = 3'd4;

   localparam logic KindWrite = 1'b0;
   localparam logic KindEval  = 1'b1;

   // Datapath commands from the controller.
   typedef struct packed {
      logic load;       // capture request item
      logic write_pt;   // write table entry
      logic rd_seg;     // register knots at seg index, compare
      logic seg_next;   // advance seg index
      logic div_start;  // start divider
      logic mul_step;   // advance multiply sequencer
      logic finish;     // form result
   } cmd_type;

   typedef struct packed {
      logic is_write;
      logic cnt_le1;
      logic seg_hit;
      logic seg_last;
      logic short_seg;
      logic div_done;
      logic mul_done;
   } sts_type;
endpackage
`default_nettype wire

### sv/kce_datapath.sv
// Datapath: knot table, segment search, serial divider and multiply sequencer.
`default_nettype none
`include "keyframe_curve_evaluator_core_assert.svh"
module kce_datapath #(
   parameter int MAX_POINTS = kce_pkg::MaxPoints,
   parameter int FRAC_BITS  = kce_pkg::FracBits
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire kce_pkg::cmd_type      cmd,
   output kce_pkg::sts_type           sts,
   input  wire logic                  kind,
   input  wire logic [3:0]            point_index,
   input  wire logic [15:0]           point_time,
   input  wire logic [15:0]           point_value,
   input  wire logic [2:0]            point_mode,
   input  wire logic [15:0]           eval_time,
   input  wire logic [4:0]            point_count,
   output logic [15:0]                curve_value,
   output logic [3:0]                 segment_index,
   output logic                       segment_missed
);
   localparam int IW  = $clog2(MAX_POINTS);
   localparam int VW  = FRAC_BITS + 1;
   localparam int PW  = 2 * VW;
   localparam int DW  = FRAC_BITS + VW;
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int NW  = (CW > 5) ? CW : 5;
   localparam int DCW = $clog2(DW + 1);
   localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

   logic [VW-1:0] times_ff  [MAX_POINTS];
   logic [VW-1:0] values_ff [MAX_POINTS];
   logic [2:0]    modes_ff  [MAX_POINTS];
   logic [MAX_POINTS-1:0] wr_ok_ff;

   logic          kind_ff;
   logic [3:0]    pidx_ff;
   logic [VW-1:0] ptime_ff, pval_ff, t_ff;
   logic [2:0]    pmode_ff;
   logic [CW-1:0] count_ff;
   logic [IW-1:0] seg_ff;
   logic [VW-1:0] t0_ff, t1_ff, v0_ff, v1_ff, vlast_ff, vfirst_ff;
   logic [2:0]    mode_ff;

   logic [15:0]   in_t, in_v, in_e;
   logic [NW-1:0] pc_ext;
   assign in_t = point_time;
   assign in_v = point_value;
   assign in_e = eval_time;
   assign pc_ext = NW'(point_count);

   function automatic logic [VW-1:0] clamp16(input logic [15:0] v);
      logic [31:0] w;
      w = 32'(v);
      clamp16 = (w > 32'(ONE)) ? ONE : VW'(w);
   endfunction

   // knot storage reads: entries never written hold reset value
   function automatic logic [VW-1:0] rst_tv(input int i);
      rst_tv = (i == 1) ? ONE : '0;
   endfunction

   logic [IW-1:0] seg_nx;
   assign seg_nx = seg_ff + IW'(1);
   logic [VW-1:0] rd_t0, rd_t1, rd_v0, rd_v1, rd_vl;
   logic [2:0]    rd_m;
   logic [IW-1:0] last_idx;
   assign last_idx = IW'(count_ff - CW'(1));
   assign rd_t0 = wr_ok_ff[seg_ff] ? times_ff[seg_ff] : rst_tv(int'(seg_ff));
   assign rd_t1 = wr_ok_ff[seg_nx] ? times_ff[seg_nx] : rst_tv(int'(seg_nx));
   assign rd_v0 = wr_ok_ff[seg_ff] ? values_ff[seg_ff] : rst_tv(int'(seg_ff));
   assign rd_v1 = wr_ok_ff[seg_nx] ? values_ff[seg_nx] : rst_tv(int'(seg_nx));
   assign rd_vl = wr_ok_ff[last_idx] ? values_ff[last_idx] : rst_tv(int'(last_idx));
   assign rd_m  = wr_ok_ff[seg_ff] ? modes_ff[seg_ff] : kce_pkg::ModeLinear;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ok_ff <= '0;
      end else if (cmd.write_pt && (32'(pidx_ff) < 32'(MAX_POINTS))) begin
         wr_ok_ff[IW'(pidx_ff)] <= 1'b1;
      end
      if (cmd.write_pt && (32'(pidx_ff) < 32'(MAX_POINTS))) begin
         times_ff[IW'(pidx_ff)]  <= ptime_ff;
         values_ff[IW'(pidx_ff)] <= pval_ff;
         modes_ff[IW'(pidx_ff)]  <= pmode_ff;
      end
   end

   // divider: u = ((t - t0) << F) / len, restoring, one bit a cycle
   logic [DW-1:0]   quo_ff;
   logic [VW:0]     rem_ff;
   logic [VW-1:0]   den_ff;
   logic [DCW-1:0]  dcnt_ff;
   logic            dbusy_ff;
   logic [VW:0]     rem_sh;
   assign rem_sh = {rem_ff[VW-1:0], quo_ff[DW-1]};

   // multiply sequencer: one product per step
   logic [3:0]    mstep_ff;
   logic [VW-1:0] u_ff, ua_ff, ub_ff, uc_ff, ud_ff;
   logic          ua_lsb_ff, ub_lsb_ff;
   logic [PW+2:0] acc_ff;
   logic [PW-1:0] mul_res;
   logic [VW-1:0] ma, mb;
   assign mul_res = PW'(ma) * PW'(mb);
   logic [VW-1:0] hi;
   assign hi = VW'(mul_res >> FRAC_BITS);

   logic          dir_ff;
   logic [VW-1:0] d_ff;

   always_comb begin
      ma = '0;
      mb = '0;
      case (mstep_ff)
         4'd0: begin ma = u_ff; mb = u_ff; end
         4'd1: begin ma = ua_ff; mb = u_ff; end
         4'd2: begin ma = ONE - u_ff; mb = ONE - u_ff; end
         4'd3: begin ma = ub_ff; mb = ONE - u_ff; end
         4'd4: begin ma = ub_ff; mb = u_ff; end
         4'd5: begin ma = ONE - u_ff; mb = ua_ff; end
         4'd6: begin ma = ud_ff; mb = v0_ff; end
         4'd7: begin ma = uc_ff; mb = v1_ff; end
         4'd8: begin ma = d_ff; mb = uc_ff; end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   // ease from products gathered in steps 0..2 (ua=u*u, ub=m*m, lsb = next bit down)
   logic [VW-1:0] e_val;
   always_comb begin
      case (mode_ff)
         kce_pkg::ModeIn:  e_val = ua_ff;
         kce_pkg::ModeOut: e_val = ONE - ub_ff;
         kce_pkg::ModeInOut: begin
            if (u_ff < (ONE >> 1)) e_val = VW'({ua_ff, ua_lsb_ff});
            else e_val = ONE - VW'({ub_ff, ub_lsb_ff});
         end
         default: e_val = u_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= kind;
         pidx_ff  <= point_index;
         ptime_ff <= clamp16(in_t);
         pval_ff  <= clamp16(in_v);
         pmode_ff <= point_mode;
         t_ff     <= clamp16(in_e);
         count_ff <= (pc_ext > NW'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(point_count);
         seg_ff   <= '0;
      end
      if (cmd.seg_next) seg_ff <= seg_nx;
      if (cmd.rd_seg) begin
         t0_ff <= rd_t0;
         t1_ff <= rd_t1;
         v0_ff <= rd_v0;
         v1_ff <= rd_v1;
         mode_ff <= rd_m;
         vlast_ff <= rd_vl;
         vfirst_ff <= wr_ok_ff[0] ? values_ff[0] : '0;
      end
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         quo_ff <= DW'(t_ff - t0_ff) << FRAC_BITS;
         rem_ff <= '0;
         den_ff <= t1_ff - t0_ff;
         dcnt_ff <= '0;
         dbusy_ff <= 1'b1;
         mstep_ff <= '0;
         acc_ff <= '0;
      end else if (dbusy_ff) begin
         if (rem_sh >= (VW+1)'(den_ff)) begin
            rem_ff <= rem_sh - (VW+1)'(den_ff);
            quo_ff <= {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[DW-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + DCW'(1);
         if (32'(dcnt_ff) == DW - 1) begin
            dbusy_ff <= 1'b0;
         end
      end
      if (cmd.mul_step) begin
         mstep_ff <= mstep_ff + 4'd1;
         case (mstep_ff)
            4'd0: begin
               ua_ff <= hi;
               ua_lsb_ff <= mul_res[FRAC_BITS-1];
            end
            4'd1: begin uc_ff <= hi; end
            4'd2: begin
               ub_ff <= hi;
               ub_lsb_ff <= mul_res[FRAC_BITS-1];
            end
            4'd3: begin ud_ff <= hi; end
            4'd4: begin acc_ff <= (PW+3)'(hi) * 3; end
            4'd5: begin
               // a = m3 + 3*(m2*u); b = 3*(m*u2) + u3
               ud_ff <= VW'(32'(ud_ff) + 32'(acc_ff));
               uc_ff <= VW'(32'(hi) * 3 + 32'(uc_ff));
            end
            4'd6: begin acc_ff <= (PW+3)'(mul_res); end
            4'd7: begin
               acc_ff <= acc_ff + (PW+3)'(mul_res);
               // non-cubic modes: uc takes the eased fraction for step 8
               if (mode_ff != kce_pkg::ModeCubic) uc_ff <= e_val;
            end
            4'd8: begin
               if (mode_ff != kce_pkg::ModeCubic) acc_ff <= (PW+3)'(mul_res);
            end
            default: begin end
         endcase
      end
      if (cmd.div_start == 1'b0 && dbusy_ff && (32'(dcnt_ff) == DW - 1)) begin
         u_ff <= VW'({quo_ff[DW-2:0], (rem_sh >= (VW+1)'(den_ff))});
      end
      if (cmd.rd_seg) begin
         dir_ff <= (rd_v1 >= rd_v0);
         d_ff   <= (rd_v1 >= rd_v0) ? rd_v1 - rd_v0 : rd_v0 - rd_v1;
      end
   end

   logic [VW-1:0] cubic_res, lin_res, qd;
   logic [PW+2:0] csh;
   assign csh = acc_ff >> FRAC_BITS;
   assign cubic_res = (csh > (PW+3)'(ONE)) ? ONE : VW'(csh);
   assign qd = VW'(acc_ff >> FRAC_BITS);
   assign lin_res = dir_ff ? v0_ff + qd : v0_ff - qd;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (sts.cnt_le1) begin
            curve_value <= 16'((count_ff == CW'(1)) ? vfirst_ff : '0);
            segment_index <= '0;
            segment_missed <= 1'b1;
         end else if (!sts.seg_hit) begin
            curve_value <= 16'(vlast_ff);
            segment_index <= '0;
            segment_missed <= 1'b1;
         end else begin
            curve_value <= sts.short_seg ? 16'(v0_ff)
                         : (mode_ff == kce_pkg::ModeCubic) ? 16'(cubic_res)
                         : 16'(lin_res);
            segment_index <= 4'(seg_ff);
            segment_missed <= 1'b0;
         end
      end
   end

   assign sts.is_write  = (kind_ff == kce_pkg::KindWrite);
   assign sts.cnt_le1   = (count_ff < CW'(2));
   assign sts.seg_hit   = (t_ff >= t0_ff) && (t_ff <= t1_ff);
   assign sts.seg_last  = (32'(seg_ff) + 2 >= 32'(count_ff));
   assign sts.short_seg = ((t1_ff - t0_ff) < VW'(kce_pkg::MinSegLen));
   assign sts.div_done  = !dbusy_ff;
   assign sts.mul_done  = (mstep_ff == 4'd9);

   `KCE_ASSERT_IMP(a_div_idle_on_start, clock, reset, cmd.div_start, !dbusy_ff, "div restarted busy")
   `KCE_ASSERT_NXT(a_div_busy, clock, reset, cmd.div_start, dbusy_ff, "divider did not start")
   `KCE_ASSERT_IMP(a_mul_steps, clock, reset, cmd.mul_step, mstep_ff < 4'd9, "mul overrun")
endmodule
`default_nettype wire

### sv/kce_ctrl.sv
// Controller: sequences load, search, divide, multiply and result handshake.
`default_nettype none
`include "keyframe_curve_evaluator_core_assert.svh"
module kce_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output kce_pkg::cmd_type      cmd,
   input  wire kce_pkg::sts_type sts
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_READ, S_CHECK, S_DIV_GO, S_DIV, S_MUL, S_FIN, S_OUT
   } state_type;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: if (req_tvalid && req_tready) begin
            cmd.load = 1'b1;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            if (sts.is_write) begin
               cmd.write_pt = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.rd_seg = 1'b1;
               state_in = sts.cnt_le1 ? S_FIN : S_CHECK;
            end
         end
         S_READ: begin
            cmd.rd_seg = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.seg_hit) state_in = sts.short_seg ? S_FIN : S_DIV_GO;
            else if (sts.seg_last) state_in = S_FIN;
            else begin
               cmd.seg_next = 1'b1;
               state_in = S_READ;
            end
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: if (sts.div_done) state_in = S_MUL;
         S_MUL: begin
            if (sts.mul_done) state_in = S_FIN;
            else cmd.mul_step = 1'b1;
         end
         // result register is written only once the previous item has left
         S_FIN: if (!rsp_valid_ff) begin
            cmd.finish = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `KCE_ASSERT_IMP(a_fin_free, clock, reset, cmd.finish, !rsp_valid_ff, "result overwritten")
   `KCE_ASSERT_NXT(a_out_valid, clock, reset, state_ff == S_OUT, rsp_valid_ff, "result lost")
   `KCE_ASSERT_IMP(a_no_accept, clock, reset, state_ff != S_IDLE, !req_tready, "accept while busy")
endmodule
`default_nettype wire

### sv/keyframe_curve_evaluator_core.sv
// Top level of the keyframe curve evaluator.
// req channel: tuser = kind (0 write point, 1 evaluate); tdata from bit 0:
//   point_index[3:0], point_time[19:4], point_value[35:20], point_mode[38:36],
//   eval_time[54:39], zero fill to 56 bits.
// rsp channel: tdata from bit 0: curve_value[15:0], segment_index[19:16],
//   segment_missed[20], zero fill to 24 bits. One rsp item per evaluate item.
// csr channel: writes point_count (5 bits); the user must write it only while
// idle, as the block does not enforce it. A write item is loaded, then written
// to the table. An evaluate item is loaded, searched segment by segment, then
// passed through divider and multiply sequencer before rsp_tvalid; the restoring
// divider makes one quotient bit per cycle. Short or missed cases skip both.
// One item is worked at a time; the next is taken once the previous is done.
// Reset (synchronous) restores the table to points (0,0) and (1.0,1.0), linear,
// and point_count 2. A stalled rsp holds its item; the next request is still
// taken and worked, and its result waits until the held item leaves.
`default_nettype none
module keyframe_curve_evaluator_core #(
   parameter int MAX_POINTS = kce_pkg::MaxPoints,
   parameter int FRAC_BITS  = kce_pkg::FracBits
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,  // point_index, point_time, point_value, point_mode, eval_time
   input  wire logic        req_tuser,  // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // curve_value, segment_index, segment_missed
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [4:0]  csr_data
);
   kce_pkg::cmd_type cmd;
   kce_pkg::sts_type sts;
   logic [4:0]  point_count_ff;
   logic [15:0] curve_value;
   logic [3:0]  segment_index;
   logic        segment_missed;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) point_count_ff <= 5'd2;
      else if (csr_valid) point_count_ff <= csr_data;
   end

   kce_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .cmd, .sts
   );

   kce_datapath #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .kind(req_tuser),
      .point_index(req_tdata[3:0]),
      .point_time(req_tdata[19:4]),
      .point_value(req_tdata[35:20]),
      .point_mode(req_tdata[38:36]),
      .eval_time(req_tdata[54:39]),
      .point_count(point_count_ff),
      .curve_value, .segment_index, .segment_missed
   );

   assign rsp_tdata = {3'd0, segment_missed, segment_index, curve_value};
endmodule
`default_nettype wire
